// ----- hdl/hsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hsc_pkg;

    localparam int unsigned IDX_W      = 5;
    localparam int unsigned CODE_W     = 14;
    localparam int unsigned CP_W       = 16;
    localparam int unsigned OUT_DEPTH  = 4;
    localparam int unsigned OUT_PTR_W  = 2;
    localparam int unsigned OUT_LVL_W  = 3;

    localparam logic [1:0] OP_JAMO   = 2'd0;
    localparam logic [1:0] OP_DOT    = 2'd1;
    localparam logic [1:0] OP_COMMIT = 2'd2;

    localparam logic [IDX_W-1:0]  NONE_IDX   = 5'd31;
    localparam logic [IDX_W-1:0]  N_LEADS    = 5'd19;
    localparam logic [IDX_W-1:0]  N_VOWELS   = 5'd21;
    localparam logic [IDX_W-1:0]  N_FINALS   = 5'd28;
    localparam logic [IDX_W-1:0]  V_I        = 5'd20;
    localparam logic [IDX_W-1:0]  V_EU       = 5'd18;
    localparam logic [CP_W-1:0]   SYL_BASE   = 16'hAC00;
    localparam logic [CODE_W-1:0] VOWEL_BASE = 14'h314F;
    localparam logic [CODE_W-1:0] VOWEL_LAST = 14'h3163;

    typedef enum logic [1:0] {
        KIND_LEAD,
        KIND_VOWEL,
        KIND_DOT,
        KIND_COMMIT
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  idx;
    } item_t;

    typedef struct packed {
        logic                 fire;
        logic [OUT_LVL_W-1:0] level;
    } back_status_t;

    function automatic logic [CP_W-1:0] lead_code(input logic [IDX_W-1:0] l);
        case (l)
            5'd0:    lead_code = 16'h3131;
            5'd1:    lead_code = 16'h3132;
            5'd2:    lead_code = 16'h3134;
            5'd3:    lead_code = 16'h3137;
            5'd4:    lead_code = 16'h3138;
            5'd5:    lead_code = 16'h3139;
            5'd6:    lead_code = 16'h3141;
            5'd7:    lead_code = 16'h3142;
            5'd8:    lead_code = 16'h3143;
            5'd9:    lead_code = 16'h3145;
            5'd10:   lead_code = 16'h3146;
            5'd11:   lead_code = 16'h3147;
            5'd12:   lead_code = 16'h3148;
            5'd13:   lead_code = 16'h3149;
            5'd14:   lead_code = 16'h314A;
            5'd15:   lead_code = 16'h314B;
            5'd16:   lead_code = 16'h314C;
            5'd17:   lead_code = 16'h314D;
            5'd18:   lead_code = 16'h314E;
            default: lead_code = 16'h0000;
        endcase
    endfunction

    // reverse of lead_code; NONE_IDX for anything not a simple lead
    function automatic logic [IDX_W-1:0] lead_of(input logic [CODE_W-1:0] c);
        case (c)
            14'h3131: lead_of = 5'd0;
            14'h3132: lead_of = 5'd1;
            14'h3134: lead_of = 5'd2;
            14'h3137: lead_of = 5'd3;
            14'h3138: lead_of = 5'd4;
            14'h3139: lead_of = 5'd5;
            14'h3141: lead_of = 5'd6;
            14'h3142: lead_of = 5'd7;
            14'h3143: lead_of = 5'd8;
            14'h3145: lead_of = 5'd9;
            14'h3146: lead_of = 5'd10;
            14'h3147: lead_of = 5'd11;
            14'h3148: lead_of = 5'd12;
            14'h3149: lead_of = 5'd13;
            14'h314A: lead_of = 5'd14;
            14'h314B: lead_of = 5'd15;
            14'h314C: lead_of = 5'd16;
            14'h314D: lead_of = 5'd17;
            14'h314E: lead_of = 5'd18;
            default:  lead_of = NONE_IDX;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] vowel_pair(input logic [IDX_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
        case ({a, b})
            {5'd8,  5'd0}:  vowel_pair = 5'd9;
            {5'd8,  5'd1}:  vowel_pair = 5'd10;
            {5'd8,  5'd20}: vowel_pair = 5'd11;
            {5'd13, 5'd4}:  vowel_pair = 5'd14;
            {5'd13, 5'd5}:  vowel_pair = 5'd15;
            {5'd13, 5'd20}: vowel_pair = 5'd16;
            {5'd18, 5'd20}: vowel_pair = 5'd19;
            {5'd0,  5'd20}: vowel_pair = 5'd1;
            {5'd2,  5'd20}: vowel_pair = 5'd3;
            {5'd4,  5'd20}: vowel_pair = 5'd5;
            {5'd6,  5'd20}: vowel_pair = 5'd7;
            default:        vowel_pair = NONE_IDX;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] final_pair(input logic [IDX_W-1:0] a,
                                                    input logic [IDX_W-1:0] b);
        case ({a, b})
            {5'd1,  5'd19}: final_pair = 5'd3;
            {5'd4,  5'd12}: final_pair = 5'd5;
            {5'd4,  5'd18}: final_pair = 5'd6;
            {5'd8,  5'd0}:  final_pair = 5'd9;
            {5'd8,  5'd6}:  final_pair = 5'd10;
            {5'd8,  5'd7}:  final_pair = 5'd11;
            {5'd8,  5'd19}: final_pair = 5'd12;
            {5'd8,  5'd25}: final_pair = 5'd13;
            {5'd8,  5'd26}: final_pair = 5'd14;
            {5'd8,  5'd15}: final_pair = 5'd15;
            {5'd17, 5'd19}: final_pair = 5'd18;
            default:        final_pair = NONE_IDX;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] final_mod(input logic [IDX_W-1:0] f);
        final_mod = (f >= N_FINALS) ? (f - N_FINALS) : f;
    endfunction

    // final that moves on as next lead; NONE_IDX when it stays
    function automatic logic [IDX_W-1:0] final_to_lead(input logic [IDX_W-1:0] f);
        case (f)
            5'd1:    final_to_lead = 5'd0;
            5'd2:    final_to_lead = 5'd1;
            5'd4:    final_to_lead = 5'd2;
            5'd7:    final_to_lead = 5'd3;
            5'd8:    final_to_lead = 5'd5;
            5'd12:   final_to_lead = 5'd9;
            5'd13:   final_to_lead = 5'd16;
            5'd14:   final_to_lead = 5'd17;
            5'd15:   final_to_lead = 5'd18;
            5'd16:   final_to_lead = 5'd6;
            5'd17:   final_to_lead = 5'd7;
            5'd19:   final_to_lead = 5'd9;
            5'd20:   final_to_lead = 5'd10;
            5'd21:   final_to_lead = 5'd11;
            5'd22:   final_to_lead = 5'd12;
            5'd23:   final_to_lead = 5'd14;
            5'd24:   final_to_lead = 5'd15;
            5'd25:   final_to_lead = 5'd16;
            5'd26:   final_to_lead = 5'd17;
            5'd27:   final_to_lead = 5'd18;
            default: final_to_lead = NONE_IDX;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] lead_to_final(input logic [IDX_W-1:0] l);
        case (l)
            5'd0:    lead_to_final = 5'd1;
            5'd1:    lead_to_final = 5'd2;
            5'd2:    lead_to_final = 5'd4;
            5'd3:    lead_to_final = 5'd7;
            5'd5:    lead_to_final = 5'd8;
            5'd6:    lead_to_final = 5'd16;
            5'd7:    lead_to_final = 5'd17;
            5'd9:    lead_to_final = 5'd19;
            5'd10:   lead_to_final = 5'd20;
            5'd11:   lead_to_final = 5'd21;
            5'd12:   lead_to_final = 5'd22;
            5'd14:   lead_to_final = 5'd23;
            5'd15:   lead_to_final = 5'd24;
            5'd16:   lead_to_final = 5'd25;
            5'd17:   lead_to_final = 5'd26;
            5'd18:   lead_to_final = 5'd27;
            default: lead_to_final = 5'd0;
        endcase
    endfunction

    // pending syllable as a code point: full syllable, or bare lead without vowel
    function automatic logic [CP_W-1:0] emit_code(input logic [IDX_W-1:0] l,
                                                  input logic [IDX_W-1:0] v,
                                                  input logic [IDX_W-1:0] f);
        logic [CP_W-1:0] lv;
        lv = 16'(l) * 16'd21 + 16'(v);
        if (v >= N_VOWELS)
            emit_code = lead_code(l);
        else
            emit_code = SYL_BASE + lv * 16'd28 + 16'(final_mod(f));
    endfunction

endpackage

`default_nettype wire

// ----- hdl/hsc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsc_front
(
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [15:0]                s_axis_tdata,  // [13:0] jamo_code
    input  wire logic [1:0]                 s_axis_tuser,  // [1:0] operation
    input  wire logic                       q_full,
    output logic                            push,
    output hsc_pkg::item_t                  item
);

    logic [hsc_pkg::CODE_W-1:0] code;
    logic [hsc_pkg::IDX_W-1:0]  lead;
    logic                       keep;

    assign code          = s_axis_tdata[hsc_pkg::CODE_W-1:0];
    assign lead          = hsc_pkg::lead_of(code);
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full && keep;

    // unknown codes and unknown operations are taken and dropped here
    always_comb
    begin
        keep      = 1'b0;
        item.kind = hsc_pkg::KIND_COMMIT;
        item.idx  = '0;
        case (s_axis_tuser)
            hsc_pkg::OP_JAMO:
            begin
                if (code inside {[hsc_pkg::VOWEL_BASE:hsc_pkg::VOWEL_LAST]})
                begin
                    keep      = 1'b1;
                    item.kind = hsc_pkg::KIND_VOWEL;
                    item.idx  = hsc_pkg::IDX_W'(code - hsc_pkg::VOWEL_BASE);
                end
                else if (lead != hsc_pkg::NONE_IDX)
                begin
                    keep      = 1'b1;
                    item.kind = hsc_pkg::KIND_LEAD;
                    item.idx  = lead;
                end
            end
            hsc_pkg::OP_DOT:
            begin
                keep      = 1'b1;
                item.kind = hsc_pkg::KIND_DOT;
            end
            hsc_pkg::OP_COMMIT:
            begin
                keep      = 1'b1;
                item.kind = hsc_pkg::KIND_COMMIT;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/hsc_item_q.sv -----
`timescale 1ns / 1ps
`default_nettype none

// two-entry queue of decoded words between front and back
module hsc_item_q
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire hsc_pkg::item_t item_in,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output hsc_pkg::item_t      item_out
);

    hsc_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign item_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

endmodule

`default_nettype wire

// ----- hdl/hsc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// composing automaton plus a four-word output buffer
module hsc_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire hsc_pkg::item_t q_item,
    output logic                q_pop,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [15:0]         m_axis_tdata,  // [15:0] code_point
    output logic                m_axis_tlast,  // last_of_run
    output hsc_pkg::back_status_t status
);

    localparam int unsigned W = hsc_pkg::IDX_W;

    logic [W-1:0] lead_reg, lead_next;
    logic [W-1:0] vowel_reg, vowel_next;
    logic [W-1:0] final_reg, final_next;
    logic [1:0]   dot_reg, dot_next;

    logic [hsc_pkg::CP_W-1:0] out_cp_reg [hsc_pkg::OUT_DEPTH];
    logic                     out_last_reg [hsc_pkg::OUT_DEPTH];
    logic [hsc_pkg::OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hsc_pkg::OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hsc_pkg::OUT_LVL_W-1:0] level_reg, level_next;

    logic                     fire;
    logic                     out_pop;
    logic [1:0]               n_out;
    logic [hsc_pkg::CP_W-1:0] cp0, cp1, vcp;
    logic                     done;
    logic [W-1:0]             carry, nv, nt, lf;

    // room for two words is needed before an item is taken
    assign fire    = q_valid && (level_reg <= hsc_pkg::OUT_LVL_W'(hsc_pkg::OUT_DEPTH - 2));
    assign q_pop   = fire;
    assign out_pop = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = (level_reg != '0);
    assign m_axis_tdata  = out_cp_reg[rd_ptr_reg];
    assign m_axis_tlast  = out_last_reg[rd_ptr_reg];

    assign status.fire  = fire;
    assign status.level = level_reg;

    always_comb
    begin
        lead_next  = lead_reg;
        vowel_next = vowel_reg;
        final_next = final_reg;
        dot_next   = dot_reg;
        n_out      = 2'd0;
        cp0        = '0;
        cp1        = '0;
        done       = 1'b0;
        carry      = hsc_pkg::final_to_lead(hsc_pkg::final_mod(final_reg));
        nv         = hsc_pkg::vowel_pair(vowel_reg, q_item.idx);
        nt         = hsc_pkg::final_pair(final_reg, q_item.idx);
        lf         = hsc_pkg::lead_to_final(q_item.idx);
        vcp        = {2'b00, hsc_pkg::VOWEL_BASE} + hsc_pkg::CP_W'(q_item.idx);

        case (q_item.kind)
            hsc_pkg::KIND_VOWEL:
            begin
                if (dot_reg != 2'd0)
                begin
                    if (vowel_reg >= hsc_pkg::N_VOWELS)
                    begin
                        if (q_item.idx == hsc_pkg::V_I)
                            vowel_next = (dot_reg == 2'd1) ? 5'd0 : 5'd2;
                        else if (q_item.idx == hsc_pkg::V_EU)
                            vowel_next = (dot_reg == 2'd1) ? 5'd8 : 5'd12;
                        else
                            vowel_next = q_item.idx;
                        done = 1'b1;
                    end
                    else if (vowel_reg == hsc_pkg::V_I)
                    begin
                        vowel_next = (dot_reg == 2'd1) ? 5'd4 : 5'd6;
                        done       = 1'b1;
                    end
                    else if (vowel_reg == hsc_pkg::V_EU)
                    begin
                        vowel_next = (dot_reg == 2'd1) ? 5'd13 : 5'd17;
                        done       = 1'b1;
                    end
                    dot_next = 2'd0;
                end
                if (!done)
                begin
                    if (lead_reg >= hsc_pkg::N_LEADS)
                    begin
                        n_out = 2'd1;
                        cp0   = vcp;
                    end
                    else if (vowel_reg >= hsc_pkg::N_VOWELS)
                    begin
                        vowel_next = q_item.idx;
                    end
                    else if (final_reg != '0 && carry != hsc_pkg::NONE_IDX)
                    begin
                        // final moves over; syllable goes out without it
                        n_out      = 2'd1;
                        cp0        = hsc_pkg::emit_code(lead_reg, vowel_reg, '0);
                        lead_next  = carry;
                        vowel_next = q_item.idx;
                        final_next = '0;
                        dot_next   = 2'd0;
                    end
                    else if (nv != hsc_pkg::NONE_IDX)
                    begin
                        vowel_next = nv;
                    end
                    else
                    begin
                        n_out      = 2'd2;
                        cp0        = hsc_pkg::emit_code(lead_reg, vowel_reg, final_reg);
                        cp1        = vcp;
                        lead_next  = hsc_pkg::NONE_IDX;
                        vowel_next = hsc_pkg::NONE_IDX;
                        final_next = '0;
                        dot_next   = 2'd0;
                    end
                end
            end
            hsc_pkg::KIND_LEAD:
            begin
                if (lead_reg >= hsc_pkg::N_LEADS)
                    lead_next = q_item.idx;
                else if (vowel_reg < hsc_pkg::N_VOWELS && final_reg == '0
                         && lf != '0)
                    final_next = lf;
                else if (vowel_reg < hsc_pkg::N_VOWELS && final_reg != '0
                         && nt != hsc_pkg::NONE_IDX)
                    final_next = nt;
                else
                begin
                    n_out      = 2'd1;
                    cp0        = hsc_pkg::emit_code(lead_reg, vowel_reg, final_reg);
                    lead_next  = q_item.idx;
                    vowel_next = hsc_pkg::NONE_IDX;
                    final_next = '0;
                    dot_next   = 2'd0;
                end
            end
            hsc_pkg::KIND_DOT:
            begin
                if (vowel_reg == hsc_pkg::V_I || vowel_reg == hsc_pkg::V_EU)
                    dot_next = dot_reg[0] ? 2'd2 : 2'd1;
                else
                    dot_next = (dot_reg == 2'd1) ? 2'd2 : 2'd1;
            end
            hsc_pkg::KIND_COMMIT:
            begin
                // without a lead nothing is cleared
                if (lead_reg < hsc_pkg::N_LEADS)
                begin
                    n_out      = 2'd1;
                    cp0        = hsc_pkg::emit_code(lead_reg, vowel_reg, final_reg);
                    lead_next  = hsc_pkg::NONE_IDX;
                    vowel_next = hsc_pkg::NONE_IDX;
                    final_next = '0;
                    dot_next   = 2'd0;
                end
            end
            default:
            begin
                n_out = 2'd0;
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        level_next  = level_reg - hsc_pkg::OUT_LVL_W'(out_pop);
        rd_ptr_next = rd_ptr_reg + hsc_pkg::OUT_PTR_W'(out_pop);
        if (fire)
        begin
            wr_ptr_next = wr_ptr_reg + hsc_pkg::OUT_PTR_W'(n_out);
            level_next  = level_next + hsc_pkg::OUT_LVL_W'(n_out);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= hsc_pkg::NONE_IDX;
            vowel_reg  <= hsc_pkg::NONE_IDX;
            final_reg  <= '0;
            dot_reg    <= 2'd0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                lead_reg  <= lead_next;
                vowel_reg <= vowel_next;
                final_reg <= final_next;
                dot_reg   <= dot_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && n_out != 2'd0)
        begin
            out_cp_reg[wr_ptr_reg]   <= cp0;
            out_last_reg[wr_ptr_reg] <= (n_out == 2'd1);
            if (n_out == 2'd2)
            begin
                out_cp_reg[wr_ptr_reg + 2'd1]   <= cp1;
                out_last_reg[wr_ptr_reg + 2'd1] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/hangul_syllable_composer.sv -----
// Data path: a kept input word is written into the item queue and taken by the composer
//   once the output buffer has room for two words; its result words are registered in
//   the output buffer, from which the receiver takes them.
// Throughput: one input word per cycle while each yields at most one result; the output
//   buffer drains one word per cycle while the receiver is ready; two-result items stall.
// Reset (rst_n low, asynchronous): no pending syllable, queues empty, no output valid.
`timescale 1ns / 1ps
`default_nettype none

module hangul_syllable_composer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [13:0] jamo_code
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [15:0] code_point
    output logic             m_axis_tlast   // last_of_run
);

    logic                  q_full;
    logic                  push;
    hsc_pkg::item_t        front_item;
    logic                  q_valid;
    logic                  q_pop;
    hsc_pkg::item_t        q_item;
    hsc_pkg::back_status_t status;

    hsc_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .item          (front_item)
    );

    hsc_item_q u_item_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .item_out (q_item)
    );

    hsc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .status        (status)
    );

    a_fire_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        status.fire |-> q_valid)
        else $error("composer took an item from an empty queue");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.level <= 3'(hsc_pkg::OUT_DEPTH))
        else $error("output buffer overflow");

    a_level_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!status.fire && !(m_axis_tvalid && m_axis_tready)) |=> $stable(status.level))
        else $error("output buffer level moved without a write or read");

endmodule

`default_nettype wire
